// File: rtl/isfp_pkg.sv
// shared constants and result type for the imu serial frame parser
package isfp_pkg;

    localparam int FRAME_LENGTH = 11;
    localparam logic [3:0] CHECK_POS = 4'(FRAME_LENGTH - 1);

    // only bytes 1..7 are read back (type byte and the three data words)
    localparam int STORE_DEPTH = 8;
    localparam int STORE_AW = $clog2(STORE_DEPTH);

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_RATE = 8'h52;

    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_RATE = 1'b1;

    typedef struct packed {
        logic               frame_kind;
        logic signed [15:0] roll_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] yaw_rate_raw;
        logic [31:0]        packet_count;
    } result_t;

endpackage

// File: rtl/imu_serial_frame_parser.sv
// top level of the imu serial frame parser
//
// Input channel s_*: one received serial byte per beat (s_rx_byte).
// Result channel m_*: one beat per frame that passes its checksum, carrying
// the frame kind (0 angle, 1 rate), the latest roll, pitch, yaw and yaw rate
// as raw signed counts, and the running count of good frames.
// Frames are 0x55, a type byte (0x53 angle, 0x52 rate), eight data bytes and
// an 8-bit sum of all earlier bytes; bad type or bad sum drops the frame.
// Throughput: one byte per cycle while s_ready is high. The parser updates its
// state in the cycle a byte is taken; a frame's result is pushed when its final
// byte is accepted and is registered in the output register or the skid slot.
// Results sit in an output register backed by one skid slot; s_ready only
// drops when both are full, i.e. when the receiver has held off two results.
// Reset (aresetn low, synchronous) returns the parser to header hunt, zeroes
// the stored angles, rate and count, and empties the result slots.
module imu_serial_frame_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_kind,
    output logic signed [15:0] m_roll_raw,
    output logic signed [15:0] m_pitch_raw,
    output logic signed [15:0] m_yaw_raw,
    output logic signed [15:0] m_yaw_rate_raw,
    output logic [31:0]        m_packet_count
);
    import isfp_pkg::*;

    logic    byte_accept;
    logic    res_push;
    result_t res_data;
    result_t out_data;

    assign byte_accept = s_valid && s_ready;

    isfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    isfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_frame_kind   = out_data.frame_kind;
    assign m_roll_raw     = out_data.roll_raw;
    assign m_pitch_raw    = out_data.pitch_raw;
    assign m_yaw_raw      = out_data.yaw_raw;
    assign m_yaw_rate_raw = out_data.yaw_rate_raw;
    assign m_packet_count = out_data.packet_count;

    // back-pressure only while a result is waiting
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // a new result only follows an accepted input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an input beat");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// File: rtl/isfp_parser.sv
// byte-at-a-time frame parser: header hunt, type check, running checksum, value update
module isfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    output logic              res_push,
    output isfp_pkg::result_t res_data
);
    import isfp_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  frame_reg [STORE_DEPTH];
    logic [15:0] roll_reg, roll_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [15:0] yaw_reg, yaw_next;
    logic [15:0] rate_reg, rate_next;
    logic [31:0] count_reg, count_next;

    logic                wr_en;
    logic [STORE_AW-1:0] wr_idx;
    logic                frame_ok;
    logic                kind;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        rate_next  = rate_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = pos_reg[STORE_AW-1:0];
        frame_ok   = 1'b0;
        kind       = KIND_ANGLE;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    if (rx_byte == TYPE_ANGLE || rx_byte == TYPE_RATE) begin
                        wr_en      = 1'b1;
                        wr_idx     = STORE_AW'(1);
                        sum_next   = sum_reg + rx_byte;
                        pos_next   = 4'd2;
                        phase_next = PH_BODY;
                    end else begin
                        phase_next = PH_HUNT;
                        pos_next   = 4'd0;
                    end
                end
                PH_BODY: begin
                    wr_en = (pos_reg < 4'(STORE_DEPTH));
                    if (pos_reg < CHECK_POS) begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end else begin
                        // last byte carries the checksum of all earlier bytes
                        phase_next = PH_HUNT;
                        pos_next   = 4'd0;
                        sum_next   = 8'd0;
                        frame_ok   = (sum_reg == rx_byte);
                    end
                end
                default: begin
                    if (rx_byte == HEADER_BYTE) begin
                        sum_next   = rx_byte;
                        pos_next   = 4'd1;
                        phase_next = PH_TYPE;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
        if (frame_ok) begin
            if (frame_reg[1] == TYPE_ANGLE) begin
                roll_next  = {frame_reg[3], frame_reg[2]};
                pitch_next = {frame_reg[5], frame_reg[4]};
                yaw_next   = {frame_reg[7], frame_reg[6]};
                kind       = KIND_ANGLE;
            end else begin
                rate_next = {frame_reg[7], frame_reg[6]};
                kind      = KIND_RATE;
            end
            count_next = count_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 4'd0;
            sum_reg   <= 8'd0;
            roll_reg  <= 16'd0;
            pitch_reg <= 16'd0;
            yaw_reg   <= 16'd0;
            rate_reg  <= 16'd0;
            count_reg <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            rate_reg  <= rate_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_reg[wr_idx] <= rx_byte;
        end
    end

    assign res_push              = frame_ok;
    assign res_data.frame_kind   = kind;
    assign res_data.roll_raw     = roll_next;
    assign res_data.pitch_raw    = pitch_next;
    assign res_data.yaw_raw      = yaw_next;
    assign res_data.yaw_rate_raw = rate_next;
    assign res_data.packet_count = count_next;

endmodule

// File: rtl/isfp_out_buf.sv
// result register with one skid slot between parser and result channel
module isfp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  isfp_pkg::result_t push_data,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output isfp_pkg::result_t out_data
);
    import isfp_pkg::*;

    logic    head_valid_reg;
    logic    skid_valid_reg;
    result_t head_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = head_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (push) begin
                    head_valid_reg <= 1'b1;
                end else begin
                    head_valid_reg <= skid_valid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (head_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload path, no reset needed
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push) begin
                head_reg <= push_data;
            end else begin
                head_reg <= skid_reg;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                skid_reg <= push_data;
            end else begin
                head_reg <= push_data;
            end
        end
    end

    assign space_ok  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

// File: verif/frame_check_pkg.sv
// frame parser predictor and result scoreboard for the testbench
`timescale 1ns / 1ps

package frame_check_pkg;

    import isfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_BODY
    } parse_phase_e;

    class frame_scoreboard;

        parse_phase_e phase;
        logic [3:0]   pos;
        logic [7:0]   held_bytes [FRAME_LENGTH];
        logic [7:0]   sum;
        logic [15:0]  roll;
        logic [15:0]  pitch;
        logic [15:0]  yaw;
        logic [15:0]  rate;
        logic [31:0]  frame_total;
        result_t      expected_frames [$];
        int           errors;

        function new();
            phase = PH_HUNT;
            pos = '0;
            foreach (held_bytes[i]) held_bytes[i] = '0;
            sum = '0;
            roll = '0;
            pitch = '0;
            yaw = '0;
            rate = '0;
            frame_total = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // note one accepted input beat and queue the frame result it completes
        function void take_byte(logic [7:0] rx);
            result_t want;
            case (phase)
                PH_TYPE: begin
                    if (rx == TYPE_ANGLE || rx == TYPE_RATE) begin
                        held_bytes[1] = rx;
                        sum = sum + rx;
                        pos = 4'd2;
                        phase = PH_BODY;
                    end else begin
                        // rejected type byte is dropped, even a header value
                        phase = PH_HUNT;
                        pos = '0;
                    end
                end
                PH_BODY: begin
                    held_bytes[pos] = rx;
                    if (int'(pos) + 1 < FRAME_LENGTH) begin
                        sum = sum + rx;
                        pos = pos + 4'd1;
                    end else begin
                        phase = PH_HUNT;
                        pos = '0;
                        if (sum == held_bytes[CHECK_POS]) begin
                            if (held_bytes[1] == TYPE_ANGLE) begin
                                roll = {held_bytes[3], held_bytes[2]};
                                pitch = {held_bytes[5], held_bytes[4]};
                                yaw = {held_bytes[7], held_bytes[6]};
                                want.frame_kind = KIND_ANGLE;
                            end else begin
                                rate = {held_bytes[7], held_bytes[6]};
                                want.frame_kind = KIND_RATE;
                            end
                            frame_total = frame_total + 32'd1;
                            want.roll_raw = roll;
                            want.pitch_raw = pitch;
                            want.yaw_raw = yaw;
                            want.yaw_rate_raw = rate;
                            want.packet_count = frame_total;
                            expected_frames.push_back(want);
                        end
                        sum = '0;
                    end
                end
                default: begin
                    if (rx == HEADER_BYTE) begin
                        held_bytes[0] = rx;
                        sum = rx;
                        pos = 4'd1;
                        phase = PH_TYPE;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
            end
        endfunction

        // compare one accepted result beat with the oldest queued frame
        function void check_frame(result_t seen);
            result_t want;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, seen);
                return;
            end
            want = expected_frames.pop_front();
            check_field("frame_kind", 32'(want.frame_kind), 32'(seen.frame_kind));
            check_field("roll_raw", 32'(want.roll_raw), 32'(seen.roll_raw));
            check_field("pitch_raw", 32'(want.pitch_raw), 32'(seen.pitch_raw));
            check_field("yaw_raw", 32'(want.yaw_raw), 32'(seen.yaw_raw));
            check_field("yaw_rate_raw", 32'(want.yaw_rate_raw), 32'(seen.yaw_rate_raw));
            check_field("packet_count", want.packet_count, seen.packet_count);
        endfunction

    endclass

endpackage

// File: verif/tb_top.sv
// top-level testbench for the imu serial frame parser
`timescale 1ns / 1ps

module tb_top;

    import isfp_pkg::*;
    import frame_check_pkg::*;

    localparam int BYTE_TARGET = 1850;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic               m_frame_kind;
    logic signed [15:0] m_roll_raw;
    logic signed [15:0] m_pitch_raw;
    logic signed [15:0] m_yaw_raw;
    logic signed [15:0] m_yaw_rate_raw;
    logic [31:0]        m_packet_count;

    frame_scoreboard sb;
    int frame_items;
    int result_count;
    int stall_cycles;

    imu_serial_frame_parser u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_roll_raw     (m_roll_raw),
        .m_pitch_raw    (m_pitch_raw),
        .m_yaw_raw      (m_yaw_raw),
        .m_yaw_rate_raw (m_yaw_rate_raw),
        .m_packet_count (m_packet_count)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        m_ready = 1'b0;
        frame_items = 0;
        result_count = 0;
        stall_cycles = 0;
        sb = new;
    end

    always #5 aclk = ~aclk;

    function automatic bit sender_idles();
        return (frame_items < 400 || frame_items >= 700) && $urandom_range(99) < 24;
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] rx);
        while (sender_idles()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        sb.take_byte(rx);
        @(negedge aclk);
    endtask

    // header, type, three data words, two random bytes and checksum; keep < 11 cuts it short
    task automatic send_frame(input bit rate_frame, input logic [15:0] w_a,
                              input logic [15:0] w_b, input logic [15:0] w_c,
                              input bit corrupt, input int keep);
        logic [7:0] bytes_out [FRAME_LENGTH];
        logic [7:0] chk;
        bytes_out[0] = HEADER_BYTE;
        bytes_out[1] = rate_frame ? TYPE_RATE : TYPE_ANGLE;
        {bytes_out[3], bytes_out[2]} = w_a;
        {bytes_out[5], bytes_out[4]} = w_b;
        {bytes_out[7], bytes_out[6]} = w_c;
        bytes_out[8] = 8'($urandom_range(255));
        bytes_out[9] = 8'($urandom_range(255));
        chk = '0;
        for (int i = 0; i < FRAME_LENGTH - 1; i++) chk = chk + bytes_out[i];
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        bytes_out[CHECK_POS] = chk;
        for (int i = 0; i < keep; i++) send_byte(bytes_out[i]);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    // stimulus
    initial begin
        int r;
        int cut;
        logic [7:0] bad_type;
        bit paused;
        paused = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // header in the type slot is dropped, then a type byte while hunting
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(TYPE_ANGLE);
        // angle frame at the word extremes, header value inside the body
        send_frame(1'b0, 16'h8000, 16'h7fff, 16'h5555, 1'b0, FRAME_LENGTH);
        // rate frame with a bad checksum
        send_frame(1'b1, 16'h0000, 16'hffff, 16'h00ff, 1'b1, FRAME_LENGTH);

        while (frame_items < BYTE_TARGET) begin
            if (!paused && frame_items >= 1000) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
            end
            r = $urandom_range(99);
            if (r < 72) begin
                send_frame(1'($urandom_range(1)), pick_word(), pick_word(), pick_word(),
                           $urandom_range(9) == 0, FRAME_LENGTH);
                frame_items += FRAME_LENGTH;
            end else if (r < 82) begin
                bad_type = 8'($urandom_range(255));
                if (bad_type == TYPE_ANGLE || bad_type == TYPE_RATE) bad_type = HEADER_BYTE;
                send_byte(HEADER_BYTE);
                send_byte(bad_type);
                frame_items += 2;
            end else if (r < 90) begin
                // short frame: the next frame's bytes land in its body
                cut = $urandom_range(2, FRAME_LENGTH - 1);
                send_frame(1'($urandom_range(1)), pick_word(), pick_word(), pick_word(),
                           1'b0, cut);
                frame_items += cut;
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // result side: random back-pressure, one long hold-off, one quiet stretch
    initial begin
        int hold_left;
        bit hold_done;
        result_t seen;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && result_count >= 20) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (result_count >= 60 && result_count < 110) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 24);
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                seen = '{frame_kind: m_frame_kind, roll_raw: m_roll_raw,
                         pitch_raw: m_pitch_raw, yaw_raw: m_yaw_raw,
                         yaw_rate_raw: m_yaw_rate_raw, packet_count: m_packet_count};
                sb.check_frame(seen);
                result_count++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
